/* hdl/sobel_edge_magnitude_rgb_unit_assert.svh */
// Assertion macros for the Sobel edge block.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SEM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sem assertion failed");
`define SEM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sem assertion failed");
`else
`define SEM_ASSERT_NOW(name, ante, cons)
`define SEM_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* hdl/sem_pkg.sv */
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 11;
  localparam int PIX_W = 24;
  localparam int SUM_W = 21;

  localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(65280);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Padding flags: which window rows/columns lie outside the frame.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edge_mask_t;

endpackage

/* hdl/sobel_edge_magnitude_rgb_unit.sv */
// An emitting pixel passes S_WIN, S_SUM, S_SQ, S_RSTART, S_ROOT and S_OUT before
// its result is valid; an item that emits nothing returns to ready after S_WIN.
// One item at a time: a new item waits until the last is through the line
// memory read/write turn plus the 8-step iterative square root and its rounding.
// Reset (rst, synchronous): width 640, height 480, counters zero; line memory
// contents are not cleared.
`include "sobel_edge_magnitude_rgb_unit_assert.svh"

module sobel_edge_magnitude_rgb_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
  input  logic                        s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // edge_red, edge_green, edge_blue
  output logic                        m_axis_tlast,  // frame_last
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [sem_pkg::DIM_W-1:0]   cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_WIN    = 3'd1;  // line data back: shift window, write back
  localparam logic [2:0] S_SUM    = 3'd2;  // Sobel sums
  localparam logic [2:0] S_SQ     = 3'd3;  // squares
  localparam logic [2:0] S_RSTART = 3'd4;  // launch roots
  localparam logic [2:0] S_ROOT   = 3'd5;  // iterate roots
  localparam logic [2:0] S_OUT    = 3'd6;  // hand to output register

  logic [2:0]                   state;
  logic [2:0]                   state_next;

  logic [sem_pkg::DIM_W-1:0]    frame_width;
  logic [sem_pkg::DIM_W-1:0]    frame_height;
  logic [sem_pkg::DIM_W-1:0]    w_eff;
  logic [sem_pkg::DIM_W-1:0]    h_eff;

  logic [sem_pkg::COL_W-1:0]    in_col;
  logic [sem_pkg::DIM_W-1:0]    in_row;
  logic [sem_pkg::COL_W-1:0]    out_col;
  logic [sem_pkg::ROW_W-1:0]    out_row;

  logic                         in_acc;
  logic                         cfg_acc;
  logic                         drain;
  logic                         skip;
  logic [sem_pkg::COL_W-1:0]    ic;
  logic [sem_pkg::DIM_W-1:0]    ic_inc;
  logic                         emit;

  logic [sem_pkg::PIX_W-1:0]    pix_hold;
  logic [sem_pkg::COL_W-1:0]    ic_hold;
  logic                         emit_hold;
  logic                         last_hold;

  logic [2*sem_pkg::PIX_W-1:0]  rd_data;
  logic                         mem_rd;
  logic                         mem_wr;

  sem_pkg::edge_mask_t          mask;
  logic [2:0][sem_pkg::SUM_W-1:0] mag_sq;
  logic [2:0]                   root_busy;
  logic [2:0]                   root_done;
  logic [2:0][7:0]              root_val;
  logic                         out_load;

  // Out-of-range sizes: zero acts as one, anything larger clamps to the max.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = sem_pkg::DIM_W'(1);
    end else if (frame_width > sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH)) begin
      w_eff = sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = sem_pkg::DIM_W'(1);
    end else if (frame_height > sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT)) begin
      h_eff = sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // A pending register write goes first; the input waits for it.
  assign s_axis_tready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign cfg_acc       = cfg_valid & cfg_ready;

  // Drain phase: all rows are in, every item (pixel or flush) pushes zeros.
  assign drain  = in_row >= h_eff;
  assign skip   = (s_axis_tuser == sem_pkg::CMD_FLUSH) & ~drain;  // early flush is dropped
  assign ic     = ({1'b0, in_col} >= w_eff) ? '0 : in_col;
  assign ic_inc = {1'b0, ic} + sem_pkg::DIM_W'(1);
  assign emit   = (in_row > sem_pkg::DIM_W'(1)) ||
                  (in_row == sem_pkg::DIM_W'(1) && ic != '0);
  assign mem_rd = in_acc & ~skip;
  assign mem_wr = (state == S_WIN);

  // Output-side padding follows the result position, not the input one.
  assign mask.top    = (out_row == '0);
  assign mask.bottom = ({1'b0, out_row} + sem_pkg::DIM_W'(1)) >= h_eff;
  assign mask.left   = (out_col == '0);
  assign mask.right  = ({1'b0, out_col} + sem_pkg::DIM_W'(1)) >= w_eff;

  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // One memory word per column: read {upper, middle}, write {middle, new}.
  sem_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (mem_rd),
    .rd_addr (ic),
    .rd_data (rd_data),
    .wr_en   (mem_wr),
    .wr_addr (ic_hold),
    .wr_data ({rd_data[sem_pkg::PIX_W-1:0], pix_hold})
  );

  sem_grad u_grad (
    .clk      (clk),
    .shift_en (mem_wr),
    .col_top  (rd_data[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W]),
    .col_mid  (rd_data[sem_pkg::PIX_W-1:0]),
    .col_bot  (pix_hold),
    .calc_en  (state == S_SUM),
    .mask     (mask),
    .sq_en    (state == S_SQ),
    .mag_sq   (mag_sq)
  );

  // One root unit per color channel, run in lockstep.
  for (genvar ch = 0; ch < 3; ch++) begin : g_root
    sem_root u_root (
      .clk   (clk),
      .rst   (rst),
      .start (state == S_RSTART),
      .sq_in (mag_sq[ch]),
      .busy  (root_busy[ch]),
      .done  (root_done[ch]),
      .root  (root_val[ch])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && !skip) begin
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        state_next = emit_hold ? S_SUM : S_IDLE;
      end
      S_SUM:    state_next = S_SQ;
      S_SQ:     state_next = S_RSTART;
      S_RSTART: state_next = S_ROOT;
      S_ROOT: begin
        if (root_done[0]) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_width   <= sem_pkg::DIM_W'(640);
      frame_height  <= sem_pkg::DIM_W'(480);
      in_col        <= '0;
      in_row        <= '0;
      out_col       <= '0;
      out_row       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end

      if (cfg_acc) begin
        // a register write restarts the frame
        if (cfg_index == sem_pkg::REG_FRAME_WIDTH) begin
          frame_width <= cfg_data;
        end else begin
          frame_height <= cfg_data;
        end
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else if (in_acc && !skip) begin
        if (ic_inc >= w_eff) begin
          in_col <= '0;
          in_row <= in_row + sem_pkg::DIM_W'(1);
        end else begin
          in_col <= ic_inc[sem_pkg::COL_W-1:0];
        end
      end else if (out_load) begin
        if (last_hold) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (mask.right) begin
          out_col <= '0;
          out_row <= out_row + sem_pkg::ROW_W'(1);
        end else begin
          out_col <= out_col + sem_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !skip) begin
      pix_hold  <= drain ? '0 : {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
      ic_hold   <= ic;
      emit_hold <= emit;
    end
    if (state == S_SUM) begin
      last_hold <= mask.bottom & mask.right;
    end
    if (out_load) begin
      m_axis_tdata <= {root_val[2], root_val[1], root_val[0]};
      m_axis_tlast <= last_hold;
    end
  end

  // Only one item in flight: the roots are quiet whenever a new one may enter.
  `SEM_ASSERT_NOW(a_idle_roots_quiet, s_axis_tready, root_busy == 3'b000)
  // Every line write-back comes in the cycle after the read of the same column.
  `SEM_ASSERT_NOW(a_write_after_read, mem_wr, $past(mem_rd))
  // The frame's final result restarts all position counters.
  `SEM_ASSERT_NEXT(a_last_restarts, out_load && last_hold && !cfg_acc,
                   in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0)

endmodule

/* hdl/sem_line_mem.sv */
module sem_line_mem (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [sem_pkg::COL_W-1:0]           rd_addr,
  output logic [2*sem_pkg::PIX_W-1:0]         rd_data,
  input  logic                                wr_en,
  input  logic [sem_pkg::COL_W-1:0]           wr_addr,
  input  logic [2*sem_pkg::PIX_W-1:0]         wr_data
);

  // {upper row, middle row} per column
  logic [2*sem_pkg::PIX_W-1:0] mem [sem_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/sem_grad.sv */
module sem_grad (
  input  logic                                 clk,
  input  logic                                 shift_en,
  input  logic [sem_pkg::PIX_W-1:0]            col_top,
  input  logic [sem_pkg::PIX_W-1:0]            col_mid,
  input  logic [sem_pkg::PIX_W-1:0]            col_bot,
  input  logic                                 calc_en,
  input  sem_pkg::edge_mask_t                  mask,
  input  logic                                 sq_en,
  output logic [2:0][sem_pkg::SUM_W-1:0]       mag_sq
);

  logic [sem_pkg::PIX_W-1:0] win [3][3];
  logic [7:0]                vv [3][3][3];
  logic signed [11:0]        gx_c [3];
  logic signed [11:0]        gy_c [3];
  logic signed [11:0]        gx [3];
  logic signed [11:0]        gy [3];
  logic signed [23:0]        px [3];
  logic signed [23:0]        py [3];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= col_top;
      win[1][2] <= col_mid;
      win[2][2] <= col_bot;
    end
  end

  // zero padding: masked taps read as zero; channel 0 sits in the top byte
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          if ((k == 0 && mask.top) || (k == 2 && mask.bottom) ||
              (j == 0 && mask.left) || (j == 2 && mask.right)) begin
            vv[ch][k][j] = 8'd0;
          end else begin
            vv[ch][k][j] = win[k][j][sem_pkg::PIX_W-1-8*ch -: 8];
          end
        end
      end
      gx_c[ch] = $signed({4'd0, vv[ch][0][2]}) + $signed({3'd0, vv[ch][1][2], 1'b0})
               + $signed({4'd0, vv[ch][2][2]}) - $signed({4'd0, vv[ch][0][0]})
               - $signed({3'd0, vv[ch][1][0], 1'b0}) - $signed({4'd0, vv[ch][2][0]});
      gy_c[ch] = $signed({4'd0, vv[ch][2][0]}) + $signed({3'd0, vv[ch][2][1], 1'b0})
               + $signed({4'd0, vv[ch][2][2]}) - $signed({4'd0, vv[ch][0][0]})
               - $signed({3'd0, vv[ch][0][1], 1'b0}) - $signed({4'd0, vv[ch][0][2]});
      px[ch] = gx[ch] * gx[ch];
      py[ch] = gy[ch] * gy[ch];
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (calc_en) begin
        gx[ch] <= gx_c[ch];
        gy[ch] <= gy_c[ch];
      end
      if (sq_en) begin
        mag_sq[ch] <= px[ch][sem_pkg::SUM_W-1:0] + py[ch][sem_pkg::SUM_W-1:0];
      end
    end
  end

endmodule

/* hdl/sem_root.sv */
module sem_root (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sem_pkg::SUM_W-1:0]   sq_in,
  output logic                        busy,
  output logic                        done,
  output logic [7:0]                  root
);

  logic                      active;
  logic                      rnd;
  logic                      sat;
  logic [sem_pkg::SUM_W-1:0] sq;
  logic [7:0]                r;
  logic [7:0]                bit_m;
  logic [7:0]                t;
  logic [15:0]               t_sq;
  logic [16:0]               rr_plus;

  assign t       = r | bit_m;
  assign t_sq    = {8'd0, t} * {8'd0, t};
  assign rr_plus = {1'b0, {8'd0, r} * {8'd0, r}} + {9'd0, r};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rnd    <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active) begin
        if (bit_m == 8'd1) begin
          active <= 1'b0;
          rnd    <= 1'b1;
        end
      end else if (rnd) begin
        rnd  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one result bit per cycle, then round half up
  always_ff @(posedge clk) begin
    if (start) begin
      sq    <= sq_in;
      sat   <= sq_in > sem_pkg::SAT_LIMIT;
      r     <= 8'd0;
      bit_m <= 8'h80;
    end else if (active) begin
      if ({5'd0, t_sq} <= sq) begin
        r <= t;
      end
      bit_m <= bit_m >> 1;
    end else if (rnd) begin
      if (!sat && sq > {4'd0, rr_plus}) begin
        r <= r + 8'd1;
      end
    end
  end

  assign busy = active | rnd;
  assign root = sat ? 8'hFF : r;

endmodule

/* bench/tb_sobel_edge_magnitude_rgb_unit.sv */
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_rgb_unit;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 24;  // longer than the emit latency

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } edge_t;

  // One line of the directed table: either a register write or an input item.
  // Where "typed" is set, the listed result replaces the predicted one.
  typedef struct {
    row_kind_t                 kind;
    logic                      idx;
    logic [sem_pkg::DIM_W-1:0] data;
    logic                      cmd;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic                      typed;
    edge_t                     res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // pixel_red, pixel_green, pixel_blue
  logic s_axis_tuser = 1'b0;       // command
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // edge_red, edge_green, edge_blue
  logic m_axis_tlast;              // frame_last
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [sem_pkg::DIM_W-1:0] cfg_data = '0;

  sobel_edge_magnitude_rgb_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Edge predictor: own copy of line memories, 3x3 window and frame counters.
  // Pixels are held as {red, green, blue}.
  // ---------------------------------------------------------------------------
  logic [sem_pkg::DIM_W-1:0] width_reg;
  logic [sem_pkg::DIM_W-1:0] height_reg;
  logic [sem_pkg::PIX_W-1:0] line_up [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] line_mid [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] win [3][3];
  int in_col, in_row, out_count;

  edge_t pending_edges[$];
  int errors = 0;
  int burst_left = 0;

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > sem_pkg::MAX_WIDTH) return sem_pkg::MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg == 0) return 1;
    if (height_reg > sem_pkg::MAX_HEIGHT) return sem_pkg::MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  // round(sqrt(s)), saturated at 255
  function automatic logic [7:0] edge_magnitude(input int s);
    int root;
    if (s > 65280) return 8'd255;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      if ((root + (1 << b)) * (root + (1 << b)) <= s) root += (1 << b);
    end
    if (s > root * root + root) root++;
    return 8'(root);
  endfunction

  task automatic sobel_predict(input logic cmd, input logic [7:0] r, g, b,
                               output logic emitted, output edge_t res);
    int w, h, ic, orow, ocol, gx, gy, v, kx, ky;
    logic drain, emit;
    logic [sem_pkg::PIX_W-1:0] pix;
    logic [7:0] mag [3];
    w = active_width();
    h = active_height();
    emitted = 1'b0;
    res = '{8'd0, 8'd0, 8'd0, 1'b0};
    drain = in_row >= h;
    // flush while pixels are still due: dropped without effect
    if (cmd == sem_pkg::CMD_FLUSH && !drain) return;
    pix = drain ? '0 : {r, g, b};
    ic = (in_col >= w) ? 0 : in_col;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = line_up[ic];
    win[1][2] = line_mid[ic];
    win[2][2] = pix;
    line_up[ic] = line_mid[ic];
    line_mid[ic] = pix;
    emit = in_row > 1 || (in_row == 1 && ic >= 1);
    ic++;
    if (ic >= w) begin
      ic = 0;
      in_row++;
    end
    in_col = ic;
    if (!emit) return;
    orow = out_count / w;
    ocol = out_count % w;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int k = 0; k < 3; k++) begin
        if ((k == 0 && orow == 0) || (k == 2 && orow + 1 >= h)) continue;
        for (int j = 0; j < 3; j++) begin
          if ((j == 0 && ocol == 0) || (j == 2 && ocol + 1 >= w)) continue;
          v = int'(win[k][j][23 - 8 * ch -: 8]);
          kx = (j - 1) * ((k == 1) ? 2 : 1);
          ky = (k - 1) * ((j == 1) ? 2 : 1);
          gx += v * kx;
          gy += v * ky;
        end
      end
      mag[ch] = edge_magnitude(gx * gx + gy * gy);
    end
    out_count++;
    res = '{mag[0], mag[1], mag[2], out_count >= w * h};
    if (res.last) begin
      in_col = 0;
      in_row = 0;
      out_count = 0;
    end
    emitted = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [7:0] r, g, b,
                           input logic typed = 1'b0,
                           input edge_t typed_res = '{8'd0, 8'd0, 8'd0, 1'b0});
    logic emitted;
    edge_t res;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    s_axis_tuser <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    sobel_predict(cmd, r, g, b, emitted, res);
    if (emitted) pending_edges.push_back(typed ? typed_res : res);
  endtask

  // Wait until every expected result is out, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [sem_pkg::DIM_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sem_pkg::REG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
    // any register write restarts the frame
    in_col = 0;
    in_row = 0;
    out_count = 0;
  endtask

  task automatic send_frame(input int w, input int h, input bit allow_abort);
    int total;
    total = w * h;
    for (int n = 0; n < total; n++) begin
      // stray flush inside the frame: ignored noise
      if ($urandom_range(0, 11) == 0)
        send_item(sem_pkg::CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      // occasionally cut the frame short; caller rewrites a register
      if (allow_abort && n > 0 && $urandom_range(0, 199) == 0) return;
      send_item(sem_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    // drain: pixels here count as flush ticks
    for (int n = 0; n <= w; n++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(sem_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_item(sem_pkg::CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready pattern changes mode every so often; check each result.
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int idle_cycles = 0;
  edge_t want;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(64, 256);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_cycle % 5) != 0;
      default: m_axis_tready <= $urandom_range(0, 9) == 0;
    endcase

    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_edges.size() == 0) begin
        $error("unexpected result transaction: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = pending_edges.pop_front();
        if (m_axis_tdata[7:0] !== want.red) begin
          $error("edge_red: expected %0d, got %0d", want.red, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[15:8] !== want.green) begin
          $error("edge_green: expected %0d, got %0d", want.green, m_axis_tdata[15:8]);
          errors++;
        end
        if (m_axis_tdata[23:16] !== want.blue) begin
          $error("edge_blue: expected %0d, got %0d", want.blue, m_axis_tdata[23:16]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end

    // watchdog: cycles with no transaction on any channel
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: reset behavior, zero-size registers (act as 1), a 1x1
  // frame (center tap has zero weight, so all-zero result), a 3x3 frame of
  // extreme values with a flush inside the frame and a pixel in the drain.
  // ---------------------------------------------------------------------------
  localparam edge_t NO_RES = '{8'd0, 8'd0, 8'd0, 1'b0};
  localparam edge_t ZERO_LAST = '{8'd0, 8'd0, 8'd0, 1'b1};

  dir_row_t directed_rows[] = '{
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_FLUSH, 8'h5a, 8'ha5, 8'h3c, 1'b0, NO_RES},
    '{ROW_CFG, sem_pkg::REG_FRAME_WIDTH, 11'd0, sem_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00,
      1'b0, NO_RES},
    '{ROW_CFG, sem_pkg::REG_FRAME_HEIGHT, 11'd0, sem_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00,
      1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'hff, 8'hff, 8'hff, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_FLUSH, 8'hff, 8'hff, 8'hff, 1'b1, ZERO_LAST},
    '{ROW_CFG, sem_pkg::REG_FRAME_WIDTH, 11'd3, sem_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00,
      1'b0, NO_RES},
    '{ROW_CFG, sem_pkg::REG_FRAME_HEIGHT, 11'd3, sem_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00,
      1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'h80, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'h7f, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'h80, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_FLUSH, 8'hff, 8'hff, 8'hff, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'h7f, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'hff, 8'hff, 8'hff, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'h01, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'hfe, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'h80, 8'h7f, 8'hff, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_PIXEL, 8'h12, 8'h34, 8'h56, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
    '{ROW_ITEM, 1'b0, 11'd0, sem_pkg::CMD_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES}
  };

  initial begin
    int pixels_sent, w, h;
    bit need_cfg;
    width_reg = sem_pkg::DIM_W'(640);
    height_reg = sem_pkg::DIM_W'(480);
    in_col = 0;
    in_row = 0;
    out_count = 0;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) win[k][j] = '0;
    for (int i = 0; i < sem_pkg::MAX_WIDTH; i++) begin
      line_up[i] = '0;
      line_mid[i] = '0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_item(directed_rows[i].cmd, directed_rows[i].red, directed_rows[i].green,
                  directed_rows[i].blue, directed_rows[i].typed, directed_rows[i].res);
    end

    // random frames, mostly small; registers sometimes out of range
    pixels_sent = 0;
    need_cfg = 1'b1;
    while (pixels_sent < 650) begin
      if (need_cfg || $urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(sem_pkg::REG_FRAME_WIDTH, sem_pkg::DIM_W'($urandom_range(1, 12)));
          write_reg(sem_pkg::REG_FRAME_HEIGHT, sem_pkg::DIM_W'($urandom_range(1, 8)));
        end else begin
          write_reg(sem_pkg::REG_FRAME_HEIGHT,
                    ($urandom_range(0, 9) == 0) ? sem_pkg::DIM_W'(0)
                                                : sem_pkg::DIM_W'($urandom_range(1, 8)));
          write_reg(sem_pkg::REG_FRAME_WIDTH,
                    ($urandom_range(0, 9) == 0) ? sem_pkg::DIM_W'(0)
                                                : sem_pkg::DIM_W'($urandom_range(1, 12)));
        end
      end
      w = active_width();
      h = active_height();
      need_cfg = 1'b0;
      send_frame(w, h, 1'b1);
      pixels_sent += w * h;
      // an aborted frame leaves counters mid-way; restart with a register write
      if (in_row != 0 || in_col != 0 || out_count != 0) need_cfg = 1'b1;
      // hold off until the pipeline is empty now and then
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    // height above the maximum acts as the maximum: a tall one-column
    // stream, cut short and restarted by the next register write
    write_reg(sem_pkg::REG_FRAME_WIDTH, sem_pkg::DIM_W'(1));
    write_reg(sem_pkg::REG_FRAME_HEIGHT, sem_pkg::DIM_W'(2047));
    for (int n = 0; n < 40; n++)
      send_item(sem_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    write_reg(sem_pkg::REG_FRAME_HEIGHT, sem_pkg::DIM_W'(3));
    write_reg(sem_pkg::REG_FRAME_WIDTH, sem_pkg::DIM_W'(2));
    send_frame(2, 3, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
